>>> rtl/core/log_ring_fifo_with_overflow_policy_core_defines.svh
// Assertion macros used by the log ring FIFO checker.
`ifndef LOG_RING_FIFO_WITH_OVERFLOW_POLICY_CORE_DEFINES_SVH
`define LOG_RING_FIFO_WITH_OVERFLOW_POLICY_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("log ring fifo check failed");

// Next-cycle implication, disabled during reset.
`define LRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("log ring fifo check failed");

`endif

>>> rtl/core/lrfifo_pkg.sv
// Types and constants of the log ring FIFO.
package lrfifo_pkg;

  localparam int PAY_W      = 64;
  localparam int OCC_W      = 10;
  localparam int MARK_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUNNING   = 2'd0,
    CFG_OVF_MODE  = 2'd1,
    CFG_HIGH_MARK = 2'd2,
    CFG_LOW_MARK  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OVF_RETRY        = 2'd0,
    OVF_DROP_ALL     = 2'd1,
    OVF_DROP_NONCRIT = 2'd2,
    OVF_PASS_CRIT    = 2'd3
  } ovf_mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic             opcode;
    logic             critical;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             dropped;
    logic             retry;
    logic             overwrote;
    logic             pop_valid;
    logic             pop_critical;
    logic [PAY_W-1:0] pop_payload;
    logic             high_water;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

endpackage

>>> rtl/core/log_ring_fifo_with_overflow_policy_core.sv
// Log ring FIFO: entry memory, pointers, overflow policy and high-water flag.
//
// For each push or pop, the item is accepted when start is high and busy is
// low, the entry memory is read at the read pointer on that edge, and the
// following cycle (busy high) applies the item, writes the memory on a stored
// push and loads the result register at its closing edge. The result then
// shows with out_valid for exactly one cycle. Busy is low in that same cycle,
// so a new item can be taken while a result shows, but not while busy is high.
// The pace is set by the registered read of the entry memory. Results cannot be
// stalled: the receiver must take out_data whenever out_valid is high. There
// is no clearing pass; the memory content after reset is undefined, and only
// written entries are ever popped. A full queue holds DEPTH-1 entries.
// Configuration writes are taken on any cycle with cfg_we.
module log_ring_fifo_with_overflow_policy_core #(
  parameter int DEPTH        = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [lrfifo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrfifo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // command
  input  logic                               start,
  output logic                               busy,
  input  lrfifo_pkg::in_item_t               in_data,
  // result
  output logic                               out_valid,
  output lrfifo_pkg::out_item_t              out_data
);
  import lrfifo_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W   = PAYLOAD_BITS + 1;
  localparam int HIGH_RV = (DEPTH * 8) / 10;
  localparam int LOW_RV  = (DEPTH * 2) / 10;
  localparam logic [MARK_W-1:0] HIGH_MARK_RST = MARK_W'(HIGH_RV);
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = MARK_W'(LOW_RV);

  // configuration registers
  logic              running_r;
  ovf_mode_t         ovf_mode_r;
  logic [MARK_W-1:0] high_mark_r;
  logic [MARK_W-1:0] low_mark_r;

  // control state
  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              hw_r, hw_nxt;
  logic              out_valid_r;

  // latched item and result
  in_item_t          cmd_r;
  out_item_t         out_data_r, out_data_nxt;

  // entry memory
  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic              mem_we;

  logic              accept;
  logic              exec_en;
  logic [PTR_W-1:0]  wr_inc;
  logic [PTR_W-1:0]  occ_nxt;
  logic [31:0]       occ_ext;
  logic              full;
  logic              empty;

  assign accept = start && !busy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b1;
      ovf_mode_r  <= OVF_RETRY;
      high_mark_r <= HIGH_MARK_RST;
      low_mark_r  <= LOW_MARK_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RUNNING:   running_r   <= cfg_wdata[0];
        CFG_OVF_MODE:  ovf_mode_r  <= ovf_mode_t'(cfg_wdata[1:0]);
        CFG_HIGH_MARK: high_mark_r <= cfg_wdata;
        CFG_LOW_MARK:  low_mark_r  <= cfg_wdata;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = 1'b0;
    exec_en = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
    endcase
  end

  // apply the latched item
  always_comb begin
    wr_inc       = wr_ptr_r + 1'b1;
    full         = (wr_inc == rd_ptr_r);
    empty        = (wr_ptr_r == rd_ptr_r);
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    hw_nxt       = hw_r;
    mem_we       = 1'b0;
    out_data_nxt = '0;

    if (cmd_r.opcode == OP_PUSH) begin
      if (!running_r) begin
        out_data_nxt.dropped = 1'b1;
      end else if (!full) begin
        mem_we = 1'b1;
      end else begin
        priority if (ovf_mode_r == OVF_RETRY) begin
          out_data_nxt.retry = 1'b1;
        end else if (ovf_mode_r == OVF_DROP_ALL || !cmd_r.critical) begin
          out_data_nxt.dropped = 1'b1;
        end else if (ovf_mode_r == OVF_DROP_NONCRIT) begin
          out_data_nxt.retry = 1'b1;
        end else begin
          // critical entry replaces the oldest one
          mem_we                 = 1'b1;
          out_data_nxt.overwrote = 1'b1;
          rd_ptr_nxt             = rd_ptr_r + 1'b1;
        end
      end
      if (mem_we) begin
        wr_ptr_nxt            = wr_inc;
        out_data_nxt.accepted = 1'b1;
      end
    end else if (running_r && !empty) begin
      rd_ptr_nxt                = rd_ptr_r + 1'b1;
      out_data_nxt.accepted     = 1'b1;
      out_data_nxt.pop_valid    = 1'b1;
      out_data_nxt.pop_critical = rd_data_r[PAYLOAD_BITS];
      out_data_nxt.pop_payload  = PAY_W'(rd_data_r[PAYLOAD_BITS-1:0]);
    end

    occ_nxt = wr_ptr_nxt - rd_ptr_nxt;
    occ_ext = 32'(occ_nxt);

    // high-water hysteresis
    if (mem_we && occ_ext >= 32'(high_mark_r)) begin
      hw_nxt = 1'b1;
    end else if (out_data_nxt.pop_valid && occ_ext <= 32'(low_mark_r)) begin
      hw_nxt = 1'b0;
    end

    out_data_nxt.high_water = hw_nxt;
    out_data_nxt.occupancy  = occ_ext[OCC_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      hw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec_en;
      if (exec_en) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        hw_r     <= hw_nxt;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_data;
    if (exec_en) out_data_r <= out_data_nxt;
  end

  // entry memory: write on a stored push, read the oldest entry on accept
  always_ff @(posedge clk) begin
    if (exec_en && mem_we) mem[wr_ptr_r] <= {cmd_r.critical, cmd_r.payload[PAYLOAD_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (accept) rd_data_r <= mem[rd_ptr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/lrfifo_checker.sv
// Port-level checks of the log ring FIFO and their bind.
`include "log_ring_fifo_with_overflow_policy_core_defines.svh"

module lrfifo_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input lrfifo_pkg::out_item_t out_data
);
  import lrfifo_pkg::*;

  logic accept;
  logic one_outcome;
  logic pop_clean;
  logic ovw_ok;

  assign accept      = start && !busy;
  assign one_outcome = $onehot0({out_data.accepted, out_data.dropped, out_data.retry});
  assign pop_clean   = out_data.pop_valid
                       || (!out_data.pop_critical && out_data.pop_payload == '0);
  assign ovw_ok      = !out_data.overwrote || out_data.accepted;

  // an accepted item keeps the block busy in the next cycle, then gives its result
  `LRF_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy && !out_valid)
  `LRF_ASSERT_NXT(a_busy_result, clk, rst_n, busy, out_valid && !busy)
  // accepted, dropped and retry of one result exclude each other; overwrote comes only with accepted
  `LRF_ASSERT_IMP(a_outcome, clk, rst_n, out_valid, one_outcome && ovw_ok)
  // pop fields are zero unless an entry came out
  `LRF_ASSERT_IMP(a_pop_clean, clk, rst_n, out_valid, pop_clean)

endmodule

bind log_ring_fifo_with_overflow_policy_core lrfifo_checker u_lrfifo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
